// ----- design/sfpr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfpr_pkg
// Types, constants and helper functions shared by the sensor frame parser.
// ----------------------------------------------------------------------------
`default_nettype none
package sfpr_pkg;

	localparam int FRAME_BYTES       = 88;
	localparam int SAMPLES_PER_FRAME = 64;
	localparam int IDX_W             = $clog2(FRAME_BYTES);
	localparam int FILL_W            = $clog2(FRAME_BYTES + 1);
	localparam int CFG_IDX_W         = 3;
	localparam int CFG_DATA_W        = 32;

	localparam logic [IDX_W-1:0] POS_HR     = IDX_W'(65);
	localparam logic [IDX_W-1:0] POS_SPO2   = IDX_W'(66);
	localparam logic [IDX_W-1:0] POS_BK     = IDX_W'(67);
	localparam logic [IDX_W-1:0] POS_STATUS = IDX_W'(87);
	localparam logic [IDX_W-1:0] POS_LAST   = IDX_W'(FRAME_BYTES - 1);
	localparam logic [IDX_W-1:0] POS_SAMPLE_LAST = IDX_W'(SAMPLES_PER_FRAME);
	localparam logic [7:0] SPO2_MAX = 8'd100;

	typedef enum logic [2:0] {
		REG_HEADER      = 3'd0,
		REG_FINGER_MASK = 3'd1,
		REG_HR_LIMIT    = 3'd2,
		REG_RESTART     = 3'd3,
		REG_RETRY       = 3'd4,
		REG_STALE       = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		RK_SAMPLE     = 2'd0,
		RK_FINGER_OFF = 2'd1,
		RK_WATCHDOG   = 2'd2
	} result_kind_t;

	typedef enum logic [2:0] {
		FLD_HEADER = 3'd0,
		FLD_HR     = 3'd1,
		FLD_SPO2   = 3'd2,
		FLD_BK     = 3'd3,
		FLD_STATUS = 3'd4
	} field_t;

	typedef enum logic [1:0] {
		RD_FIELD,
		RD_SCAN,
		RD_EMIT
	} rd_src_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FLD_RD,
		S_FLD_CAP,
		S_EVAL,
		S_SCAN_RD,
		S_SCAN_CAP,
		S_FOFF,
		S_EMIT_RD,
		S_EMIT_CAP,
		S_OUT
	} state_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        result_kind;
		logic signed [7:0] ecg_sample;
		logic [31:0]       sample_seq;
		logic [7:0]        hr_bpm;
		logic [6:0]        spo2;
		logic [7:0]        bk_value;
		logic [7:0]        status_byte;
		logic [31:0]       frame_count;
		logic [31:0]       drop_count;
		logic              send_start;
		logic              stale_clear;
		logic              last;
	} out_item_t;

	typedef struct packed {
		logic    accept;
		rd_src_t rd_src;
		logic    cap_field;
		logic    eval;
		logic    scan_cap;
		logic    foff_load;
		logic    emit_cap;
		logic    emit_next;
	} dp_cmd_t;

	typedef struct packed {
		logic tick_evt;
		logic frame_done;
		logic fld_last;
		logic ok;
		logic foff;
		logic scan_hit;
		logic scan_end;
		logic out_last;
	} dp_stat_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

	function automatic logic [IDX_W-1:0] field_pos(input field_t f);
		case (f)
			FLD_HEADER: return '0;
			FLD_HR:     return POS_HR;
			FLD_SPO2:   return POS_SPO2;
			FLD_BK:     return POS_BK;
			default:    return POS_STATUS;
		endcase
	endfunction

endpackage
`default_nettype wire

// ----- design/sfpr_ram.sv -----
// ----------------------------------------------------------------------------
// sfpr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module sfpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 88
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- design/sfpr_ctrl.sv -----
// ----------------------------------------------------------------------------
// sfpr_ctrl
// Sequencer: accepts items, walks the frame check, resync scan and emission.
// ----------------------------------------------------------------------------
`default_nettype none
module sfpr_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output sfpr_pkg::dp_cmd_t      cmd,
	input  wire sfpr_pkg::dp_stat_t st
);
	import sfpr_pkg::*;

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid && st.tick_evt) state_n = S_OUT;
				else if (in_valid && st.frame_done) state_n = S_FLD_RD;
			end
			S_FLD_RD:   state_n = S_FLD_CAP;
			S_FLD_CAP:  state_n = st.fld_last ? S_EVAL : S_FLD_RD;
			S_EVAL: begin
				if (!st.ok) state_n = S_SCAN_RD;
				else if (st.foff) state_n = S_FOFF;
				else state_n = S_EMIT_RD;
			end
			S_SCAN_RD:  state_n = S_SCAN_CAP;
			S_SCAN_CAP: state_n = (st.scan_hit || st.scan_end) ? S_IDLE : S_SCAN_RD;
			S_FOFF:     state_n = S_OUT;
			S_EMIT_RD:  state_n = S_EMIT_CAP;
			S_EMIT_CAP: state_n = S_OUT;
			S_OUT: begin
				if (out_ready) state_n = st.out_last ? S_IDLE : S_EMIT_RD;
			end
			default:    state_n = S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		cmd.rd_src = RD_FIELD;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			S_FLD_RD:   cmd.rd_src = RD_FIELD;
			S_FLD_CAP:  cmd.cap_field = 1'b1;
			S_EVAL:     cmd.eval = 1'b1;
			S_SCAN_RD:  cmd.rd_src = RD_SCAN;
			S_SCAN_CAP: cmd.scan_cap = 1'b1;
			S_FOFF:     cmd.foff_load = 1'b1;
			S_EMIT_RD:  cmd.rd_src = RD_EMIT;
			S_EMIT_CAP: cmd.emit_cap = 1'b1;
			S_OUT: begin
				out_valid     = 1'b1;
				cmd.emit_next = out_ready && !st.out_last;
			end
			default: ;
		endcase
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input taken while a result waits");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result withdrawn");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && st.out_last |=> in_ready)
		else $error("not idle after last result");
endmodule
`default_nettype wire

// ----- design/sfpr_dp.sv -----
// ----------------------------------------------------------------------------
// sfpr_dp
// Datapath: configuration, frame ring, counters, watchdog and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module sfpr_dp (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire sfpr_pkg::in_item_t             in_item,
	output sfpr_pkg::out_item_t                 out_item,
	input  wire logic                           cfg_we,
	input  wire logic [sfpr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sfpr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire sfpr_pkg::dp_cmd_t              cmd,
	output sfpr_pkg::dp_stat_t                  st
);
	import sfpr_pkg::*;

	logic [7:0]  hdr_q, fmask_q, hrlim_q;
	logic [31:0] restart_q, retry_q, stale_q;
	logic [FILL_W-1:0] fill_q, fill_n;
	logic [IDX_W-1:0]  base_q, scan_q, emit_q;
	field_t            fld_q;
	logic [31:0] scnt_q, fcnt_q, dcnt_q, sf_q, sr_q;
	logic [7:0]  last_bk_q;
	logic [7:0]  b0_q, hr_q, sp_q, bk_q, stat_q;
	out_item_t   out_q;
	out_item_t   out_n;
	logic        load_out;

	logic [31:0] sf_n, sr_n, scnt_n;
	logic        ss, sc;
	logic        wr_en, hit_hdr;
	logic [IDX_W-1:0] wlog, rlog, waddr, raddr;
	logic [7:0]  rdata;
	logic [6:0]  sp_ok;

	function automatic logic [IDX_W-1:0] to_phys(input logic [IDX_W-1:0] base,
			input logic [IDX_W-1:0] lg);
		logic [IDX_W:0] s;
		s = {1'b0, base} + {1'b0, lg};
		if (s >= (IDX_W+1)'(FRAME_BYTES)) s = s - (IDX_W+1)'(FRAME_BYTES);
		return s[IDX_W-1:0];
	endfunction

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q     <= 8'd255;
			fmask_q   <= 8'd1;
			hrlim_q   <= 8'd220;
			restart_q <= 32'd90000000;
			retry_q   <= 32'd30000000;
			stale_q   <= 32'd180000000;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_HEADER:      hdr_q     <= cfg_data[7:0];
				REG_FINGER_MASK: fmask_q   <= cfg_data[7:0];
				REG_HR_LIMIT:    hrlim_q   <= cfg_data[7:0];
				REG_RESTART:     restart_q <= cfg_data;
				REG_RETRY:       retry_q   <= cfg_data;
				REG_STALE:       stale_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Byte intake and watchdog.
	assign hit_hdr = (in_item.data_byte == hdr_q);
	always_comb begin
		wr_en = 1'b0;
		wlog  = '0;
		if (fill_q == '0) begin
			fill_n = hit_hdr ? FILL_W'(1) : '0;
			wr_en  = cmd.accept && !in_item.kind && hit_hdr;
		end else begin
			wr_en = cmd.accept && !in_item.kind;
			if (fill_q >= FILL_W'(FRAME_BYTES)) begin
				fill_n = FILL_W'(1);
			end else begin
				wlog   = fill_q[IDX_W-1:0];
				fill_n = fill_q + FILL_W'(1);
			end
		end
	end
	assign waddr = to_phys(base_q, wlog);

	assign sf_n = sat_inc(sf_q);
	assign sr_n = sat_inc(sr_q);
	assign ss   = (sf_n > restart_q) && (sr_n > retry_q);
	assign sc   = (sf_n > stale_q);

	always_comb begin
		case (cmd.rd_src)
			RD_SCAN: rlog = scan_q;
			RD_EMIT: rlog = emit_q;
			default: rlog = field_pos(fld_q);
		endcase
	end
	assign raddr = to_phys(base_q, rlog);

	sfpr_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (waddr),
		.wdata (in_item.data_byte),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign scnt_n = sat_inc(scnt_q);
	assign sp_ok  = (sp_q >= 8'd1 && sp_q <= SPO2_MAX) ? sp_q[6:0] : 7'd0;

	always_comb begin
		st            = '0;
		st.tick_evt   = in_item.kind && (ss || sc);
		st.frame_done = !in_item.kind && (fill_q == FILL_W'(FRAME_BYTES - 1));
		st.fld_last   = (fld_q == FLD_STATUS);
		st.ok         = (b0_q == hdr_q) && (hr_q <= hrlim_q) &&
		                (sp_q[7] || sp_q <= SPO2_MAX);
		st.foff       = (stat_q & fmask_q) != 8'd0;
		st.scan_hit   = (rdata == hdr_q);
		st.scan_end   = (scan_q == POS_LAST);
		st.out_last   = out_q.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			base_q    <= '0;
			scan_q    <= IDX_W'(1);
			emit_q    <= IDX_W'(1);
			fld_q     <= FLD_HEADER;
			scnt_q    <= '0;
			fcnt_q    <= '0;
			dcnt_q    <= '0;
			sf_q      <= '0;
			sr_q      <= '0;
			last_bk_q <= '0;
		end else begin
			if (cmd.accept && !in_item.kind) fill_q <= fill_n;
			if (cmd.accept && in_item.kind) begin
				sf_q <= sf_n;
				sr_q <= ss ? 32'd0 : sr_n;
			end
			if (cmd.cap_field) fld_q <= field_t'(fld_q + 3'd1);
			if (cmd.eval) begin
				fld_q  <= FLD_HEADER;
				scan_q <= IDX_W'(1);
				emit_q <= IDX_W'(1);
				if (st.ok) begin
					fill_q    <= '0;
					last_bk_q <= bk_q;
					sf_q      <= '0;
					fcnt_q    <= sat_inc(fcnt_q);
				end else begin
					dcnt_q <= sat_inc(dcnt_q);
				end
			end
			if (cmd.scan_cap) begin
				if (st.scan_hit) begin
					base_q <= to_phys(base_q, scan_q);
					fill_q <= FILL_W'(FRAME_BYTES) - FILL_W'(scan_q);
				end else if (st.scan_end) begin
					fill_q <= '0;
				end else begin
					scan_q <= scan_q + IDX_W'(1);
				end
			end
			if (cmd.emit_cap) scnt_q <= scnt_n;
			if (cmd.emit_next) emit_q <= emit_q + IDX_W'(1);
		end
	end

	// Next result item.
	always_comb begin
		out_n    = '0;
		load_out = 1'b1;
		if (cmd.accept && st.tick_evt) begin
			out_n.result_kind = RK_WATCHDOG;
			out_n.sample_seq  = scnt_q;
			out_n.bk_value    = last_bk_q;
			out_n.status_byte = sc ? fmask_q : 8'd0;
			out_n.frame_count = fcnt_q;
			out_n.drop_count  = dcnt_q;
			out_n.send_start  = ss;
			out_n.stale_clear = sc;
			out_n.last        = 1'b1;
		end else if (cmd.foff_load) begin
			out_n.result_kind = RK_FINGER_OFF;
			out_n.sample_seq  = scnt_q;
			out_n.bk_value    = bk_q;
			out_n.status_byte = stat_q;
			out_n.frame_count = fcnt_q;
			out_n.drop_count  = dcnt_q;
			out_n.last        = 1'b1;
		end else if (cmd.emit_cap) begin
			out_n.result_kind = RK_SAMPLE;
			out_n.ecg_sample  = rdata;
			out_n.sample_seq  = scnt_n;
			if (emit_q == POS_SAMPLE_LAST) begin
				out_n.hr_bpm      = hr_q;
				out_n.spo2        = sp_ok;
				out_n.bk_value    = bk_q;
				out_n.status_byte = stat_q;
				out_n.frame_count = fcnt_q;
				out_n.drop_count  = dcnt_q;
				out_n.last        = 1'b1;
			end
		end else begin
			load_out = 1'b0;
		end
	end

	// Captured header fields and the result register.
	always_ff @(posedge clk) begin
		if (cmd.cap_field) begin
			case (fld_q)
				FLD_HEADER: b0_q   <= rdata;
				FLD_HR:     hr_q   <= rdata;
				FLD_SPO2:   sp_q   <= rdata;
				FLD_BK:     bk_q   <= rdata;
				default:    stat_q <= rdata;
			endcase
		end
		if (load_out) out_q <= out_n;
	end

	assign out_item = out_q;

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(FRAME_BYTES)) else $error("fill count out of range");
	a_base_range: assert property (@(posedge clk) disable iff (!arst_n)
		base_q < IDX_W'(FRAME_BYTES)) else $error("ring base out of range");
	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_cap |-> (emit_q >= IDX_W'(1)) && (emit_q <= POS_SAMPLE_LAST))
		else $error("sample index out of range");
endmodule
`default_nettype wire

// ----- design/sensor_frame_parser_resync.sv -----
// ----------------------------------------------------------------------------
// sensor_frame_parser_resync
// Frame parser with header resync and tick watchdog for a pulse/ECG sensor.
// ----------------------------------------------------------------------------
// A received byte or a tick that causes no result is taken while idle. A
// tick with a watchdog event loads its result as it is accepted and then
// waits for it to be taken. The byte that completes a frame starts a check
// that reads five frame fields in turn; a good frame then emits 64 samples,
// or one finger-off result if a masked status bit is set, and a failed one
// scans the stored bytes for a new header via the ring's single read port.
`default_nettype none
module sensor_frame_parser_resync (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire sfpr_pkg::in_item_t              in_item,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output sfpr_pkg::out_item_t                  out_item,
	input  wire logic                            cfg_we,
	input  wire logic [sfpr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [sfpr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sfpr_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t st;

	sfpr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.st        (st)
	);

	sfpr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.st        (st)
	);
endmodule
`default_nettype wire
